FILE: rtl/quaternion_orientation_accumulator_assert.svh
// assertion macros used by the accumulator controller
`ifndef QUATERNION_ORIENTATION_ACCUMULATOR_ASSERT_SVH
`define QUATERNION_ORIENTATION_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define QOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define QOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/qoa_pkg.sv
// shared constants, command types and tables of the orientation accumulator
`timescale 1ns / 1ps
`default_nettype none
package qoa_pkg;

    // component format
    localparam int W  = 16;
    localparam int F  = 14;
    localparam int AW = 16;
    // cordic, local quaternion, product, scaled product, square sum and magnitude widths
    localparam int CW = 34;
    localparam int LW = 18;
    localparam int PW = 22;
    localparam int RW = 32;
    localparam int SW = 62;
    localparam int MW = 30;
    // quotient bits of the normalizing divide
    localparam int QB = 17;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 31;

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    // datapath operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_CORDIC    = 4'd2;
    localparam logic [3:0] OP_LOCAL     = 4'd3;
    localparam logic [3:0] OP_TERM      = 4'd4;
    localparam logic [3:0] OP_MAX       = 4'd5;
    localparam logic [3:0] OP_NORM      = 4'd6;
    localparam logic [3:0] OP_SQUARE    = 4'd7;
    localparam logic [3:0] OP_SQRT_INIT = 4'd8;
    localparam logic [3:0] OP_SQRT      = 4'd9;
    localparam logic [3:0] OP_DIV_INIT  = 4'd10;
    localparam logic [3:0] OP_DIV       = 4'd11;
    localparam logic [3:0] OP_DIV_STORE = 4'd12;
    localparam logic [3:0] OP_COMMIT    = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [4:0] cnt;
        logic [1:0] comp;
    } cmd_t;

    typedef struct packed {
        logic degen;
        logic norm_done;
    } sts_t;

    // atan(2^-i), pi = 2^30
    function automatic logic signed [CW-1:0] atan_lut(input logic [3:0] i);
        logic signed [CW-1:0] v;
        case (i)
            4'd0:    v = CW'(268435456);
            4'd1:    v = CW'(158466703);
            4'd2:    v = CW'(83729454);
            4'd3:    v = CW'(42502378);
            4'd4:    v = CW'(21333666);
            4'd5:    v = CW'(10677233);
            4'd6:    v = CW'(5339919);
            4'd7:    v = CW'(2670123);
            4'd8:    v = CW'(1335082);
            4'd9:    v = CW'(667543);
            4'd10:   v = CW'(333772);
            4'd11:   v = CW'(166886);
            4'd12:   v = CW'(83443);
            4'd13:   v = CW'(41722);
            4'd14:   v = CW'(20861);
            4'd15:   v = CW'(10430);
            default: v = '0;
        endcase
        return v;
    endfunction

    // hamilton product term k of component j (index j*4+k): {negate, l index, o index}
    function automatic logic [4:0] term_sel(input logic [3:0] idx);
        logic [4:0] v;
        case (idx)
            4'd0:    v = {1'b0, 2'd3, 2'd0};
            4'd1:    v = {1'b0, 2'd0, 2'd3};
            4'd2:    v = {1'b0, 2'd1, 2'd2};
            4'd3:    v = {1'b1, 2'd2, 2'd1};
            4'd4:    v = {1'b0, 2'd3, 2'd1};
            4'd5:    v = {1'b1, 2'd0, 2'd2};
            4'd6:    v = {1'b0, 2'd1, 2'd3};
            4'd7:    v = {1'b0, 2'd2, 2'd0};
            4'd8:    v = {1'b0, 2'd3, 2'd2};
            4'd9:    v = {1'b0, 2'd0, 2'd1};
            4'd10:   v = {1'b1, 2'd1, 2'd0};
            4'd11:   v = {1'b0, 2'd2, 2'd3};
            4'd12:   v = {1'b0, 2'd3, 2'd3};
            4'd13:   v = {1'b1, 2'd0, 2'd0};
            4'd14:   v = {1'b1, 2'd1, 2'd1};
            4'd15:   v = {1'b1, 2'd2, 2'd2};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/quaternion_orientation_accumulator.sv
// top level of the quaternion orientation accumulator
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | input     | in_valid / in_ready | axis_x, axis_y, axis_z, angle
//  out     | output    | out_valid/out_ready | quat_x/y/z/w, degenerate
//
// one beat at a time, through the 16 step cordic, 16 shared-multiplier product terms,
// 31 step square root and four 17 step restoring divides; a zero-length product
// skips the square root and the divides.
// a new beat is taken as soon as the previous one reaches the output register.
// out_ready low holds the finished beat and the next beat waits at commit.
// rst_n clears the controller and sets the orientation to identity.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_orientation_accumulator
    import qoa_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire signed [W-1:0]  axis_x,
    input  wire signed [W-1:0]  axis_y,
    input  wire signed [W-1:0]  axis_z,
    input  wire signed [AW-1:0] angle,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [W-1:0] quat_x,
    output logic signed [W-1:0] quat_y,
    output logic signed [W-1:0] quat_z,
    output logic signed [W-1:0] quat_w,
    output logic                degenerate
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    qoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic and state
    qoa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .axis_x     (axis_x),
        .axis_y     (axis_y),
        .axis_z     (axis_z),
        .angle      (angle),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .quat_w     (quat_w),
        .degenerate (degenerate)
    );

endmodule
`default_nettype wire

FILE: rtl/qoa_datapath.sv
// datapath: cordic, hamilton product, scaling, square root and divide
`timescale 1ns / 1ps
`default_nettype none
module qoa_datapath
    import qoa_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  wire signed [W-1:0]  axis_x,
    input  wire signed [W-1:0]  axis_y,
    input  wire signed [W-1:0]  axis_z,
    input  wire signed [AW-1:0] angle,
    output logic signed [W-1:0] quat_x,
    output logic signed [W-1:0] quat_y,
    output logic signed [W-1:0] quat_z,
    output logic signed [W-1:0] quat_w,
    output logic                degenerate
);

    localparam int LPW = W + CW;
    localparam int TPW = LW + W;
    localparam logic signed [LPW-1:0] L_HALF = LPW'(1) <<< 29;
    localparam logic signed [CW-1:0]  W_HALF = CW'(1) <<< (29 - F);
    localparam logic signed [TPW-1:0] T_HALF = TPW'(1) <<< (F - 1);
    localparam logic [QB:0] Q_MAX = (QB+1)'((2 ** (W - 1)) - 1);

    logic signed [W-1:0]  ax_reg [3];
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [LW-1:0] l_reg [4];
    logic signed [W-1:0]  orient_reg [4];
    logic signed [PW-1:0] p_reg [4];
    logic signed [RW-1:0] r_reg [4];
    logic [MW-1:0]        m_reg;
    logic                 degen_reg;
    logic [SW-1:0]        sum_reg, sv_reg, sr_reg;
    logic [MW-1:0]        dva_reg;
    logic [31:0]          rem_reg;
    logic [QB-1:0]        quo_reg;
    logic signed [W-1:0]  newq_reg [4];
    logic signed [W-1:0]  qx_reg, qy_reg, qz_reg, qw_reg;
    logic                 dg_reg;

    // cordic step
    logic signed [CW-1:0] xs, ys, atan_i;
    // local quaternion
    logic signed [LPW-1:0] lprod, lrnd;
    logic signed [CW-1:0]  wrnd;
    // product terms
    logic [4:0]            sel;
    logic signed [TPW-1:0] tprod, trnd;
    logic signed [PW-1:0]  tval;
    // maximum magnitude
    logic [PW-1:0]         pa [4];
    logic [PW-1:0]         m01, m23, mx;
    // scaled component select and magnitude
    logic [1:0]            ridx;
    logic signed [RW-1:0]  rsel;
    logic [MW-1:0]         rabs;
    logic [2*MW-1:0]       sq;
    // square root
    logic [5:0]            bsh;
    logic [SW-1:0]         sbit, strial;
    // divide
    logic [30:0]           len;
    logic                  nbit;
    logic [31:0]           dtrial;
    logic                  dge;
    logic [QB:0]           qr;
    logic signed [W-1:0]   qres;

    always_comb
    begin
        xs     = x_reg >>> cmd.cnt[3:0];
        ys     = y_reg >>> cmd.cnt[3:0];
        atan_i = atan_lut(cmd.cnt[3:0]);

        lprod = LPW'(ax_reg[cmd.cnt[1:0]]) * LPW'(y_reg);
        lrnd  = (lprod + L_HALF) >>> 30;
        wrnd  = (x_reg + W_HALF) >>> (30 - F);

        sel   = term_sel(cmd.cnt[3:0]);
        tprod = TPW'(l_reg[sel[3:2]]) * TPW'(orient_reg[sel[1:0]]);
        trnd  = (tprod + T_HALF) >>> F;
        tval  = sel[4] ? -PW'(trnd) : PW'(trnd);

        for (int i = 0; i < 4; i++)
        begin
            pa[i] = p_reg[i][PW-1] ? PW'(-p_reg[i]) : PW'(p_reg[i]);
        end
        m01 = (pa[0] > pa[1]) ? pa[0] : pa[1];
        m23 = (pa[2] > pa[3]) ? pa[2] : pa[3];
        mx  = (m01 > m23) ? m01 : m23;

        ridx = (cmd.op == OP_SQUARE) ? cmd.cnt[1:0] : cmd.comp;
        rsel = r_reg[ridx];
        rabs = rsel[RW-1] ? MW'(-rsel) : MW'(rsel);
        sq   = rabs * rabs;

        bsh    = 6'd60 - {cmd.cnt, 1'b0};
        sbit   = SW'(1) << bsh;
        strial = sr_reg + sbit;

        len    = (sr_reg[30:0] == '0) ? 31'd1 : sr_reg[30:0];
        nbit   = (cmd.cnt == 5'd0) ? dva_reg[1] : ((cmd.cnt == 5'd1) ? dva_reg[0] : 1'b0);
        dtrial = {rem_reg[30:0], nbit};
        dge    = dtrial >= {1'b0, len};

        qr = ({1'b0, quo_reg} + (QB+1)'(1)) >> 1;
        if (!rsel[RW-1])
        begin
            qres = (qr > Q_MAX) ? W'(Q_MAX) : W'(qr);
        end
        else
        begin
            qres = (qr > Q_MAX + (QB+1)'(1)) ? W'(Q_MAX + (QB+1)'(1)) : -W'(qr);
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                ax_reg[0] <= axis_x;
                ax_reg[1] <= axis_y;
                ax_reg[2] <= axis_z;
                x_reg     <= CORDIC_GAIN;
                y_reg     <= '0;
                z_reg     <= CW'(angle) <<< 14;
            end
            OP_CORDIC:
            begin
                if (!z_reg[CW-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_i;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_i;
                end
            end
            OP_LOCAL:
            begin
                l_reg[cmd.cnt[1:0]] <= LW'(lrnd);
                if (cmd.cnt == 5'd0)
                begin
                    l_reg[3] <= LW'(wrnd);
                end
            end
            OP_TERM:
            begin
                if (cmd.cnt[1:0] == 2'd0)
                begin
                    p_reg[cmd.cnt[3:2]] <= tval;
                end
                else
                begin
                    p_reg[cmd.cnt[3:2]] <= p_reg[cmd.cnt[3:2]] + tval;
                end
            end
            OP_MAX:
            begin
                m_reg     <= MW'(mx);
                degen_reg <= (mx == '0);
                for (int i = 0; i < 4; i++)
                begin
                    r_reg[i] <= RW'(p_reg[i]);
                end
            end
            OP_NORM:
            begin
                if (m_reg[MW-1:25] == '0)
                begin
                    m_reg <= m_reg << 4;
                    for (int i = 0; i < 4; i++)
                    begin
                        r_reg[i] <= r_reg[i] <<< 4;
                    end
                end
                else
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 4; i++)
                    begin
                        r_reg[i] <= r_reg[i] <<< 1;
                    end
                end
            end
            OP_SQUARE:
            begin
                sum_reg <= ((cmd.cnt == 5'd0) ? '0 : sum_reg) + SW'(sq);
            end
            OP_SQRT_INIT:
            begin
                sv_reg <= sum_reg;
                sr_reg <= '0;
            end
            OP_SQRT:
            begin
                if (sv_reg >= strial)
                begin
                    sv_reg <= sv_reg - strial;
                    sr_reg <= (sr_reg >> 1) + sbit;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
            end
            OP_DIV_INIT:
            begin
                dva_reg <= rabs;
                rem_reg <= 32'(rabs >> 2);
                quo_reg <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= dge ? (dtrial - {1'b0, len}) : dtrial;
                quo_reg <= {quo_reg[QB-2:0], dge};
            end
            OP_DIV_STORE:
            begin
                newq_reg[cmd.comp] <= qres;
            end
            OP_COMMIT:
            begin
                dg_reg <= degen_reg;
                qx_reg <= degen_reg ? orient_reg[0] : newq_reg[0];
                qy_reg <= degen_reg ? orient_reg[1] : newq_reg[1];
                qz_reg <= degen_reg ? orient_reg[2] : newq_reg[2];
                qw_reg <= degen_reg ? orient_reg[3] : newq_reg[3];
            end
            default:
            begin
            end
        endcase
    end

    // stored orientation, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg[0] <= '0;
            orient_reg[1] <= '0;
            orient_reg[2] <= '0;
            orient_reg[3] <= (F >= W - 1) ? W'((2 ** (W - 1)) - 1) : W'(2 ** F);
        end
        else if (cmd.op == OP_COMMIT && !degen_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                orient_reg[i] <= newq_reg[i];
            end
        end
    end

    // status and result
    assign sts.degen     = degen_reg;
    assign sts.norm_done = m_reg[MW-1];
    assign quat_x        = qx_reg;
    assign quat_y        = qy_reg;
    assign quat_z        = qz_reg;
    assign quat_w        = qw_reg;
    assign degenerate    = dg_reg;

endmodule
`default_nettype wire

FILE: rtl/qoa_ctrl.sv
// controller: sequences the datapath operations and owns the handshakes
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_orientation_accumulator_assert.svh"
module qoa_ctrl
    import qoa_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  wire   out_ready,
    output cmd_t  cmd,
    input  sts_t  sts
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CORDIC = 4'd1;
    localparam logic [3:0] S_LOCAL  = 4'd2;
    localparam logic [3:0] S_TERM   = 4'd3;
    localparam logic [3:0] S_MAX    = 4'd4;
    localparam logic [3:0] S_NORM   = 4'd5;
    localparam logic [3:0] S_SQUARE = 4'd6;
    localparam logic [3:0] S_SQRTI  = 4'd7;
    localparam logic [3:0] S_SQRT   = 4'd8;
    localparam logic [3:0] S_DIVI   = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_DIVS   = 4'd11;
    localparam logic [3:0] S_COMMIT = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_beat, out_stall, at_commit;

    // next state and command
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NOP;
        cmd.cnt        = cnt_reg;
        cmd.comp       = comp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CORDIC;
                    cnt_next   = '0;
                end
            end
            S_CORDIC:
            begin
                cmd.op   = OP_CORDIC;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = S_LOCAL;
                    cnt_next   = '0;
                end
            end
            S_LOCAL:
            begin
                cmd.op   = OP_LOCAL;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2)
                begin
                    state_next = S_TERM;
                    cnt_next   = '0;
                end
            end
            S_TERM:
            begin
                cmd.op   = OP_TERM;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    state_next = S_MAX;
                    cnt_next   = '0;
                end
            end
            S_MAX:
            begin
                cmd.op     = OP_MAX;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (sts.degen)
                begin
                    state_next = S_COMMIT;
                end
                else if (sts.norm_done)
                begin
                    state_next = S_SQUARE;
                    cnt_next   = '0;
                end
                else
                begin
                    cmd.op = OP_NORM;
                end
            end
            S_SQUARE:
            begin
                cmd.op   = OP_SQUARE;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    state_next = S_SQRTI;
                end
            end
            S_SQRTI:
            begin
                cmd.op     = OP_SQRT_INIT;
                state_next = S_SQRT;
                cnt_next   = '0;
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    state_next = S_DIVI;
                    comp_next  = '0;
                end
            end
            S_DIVI:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QB - 1))
                begin
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                cmd.op    = OP_DIV_STORE;
                comp_next = comp_reg + 2'd1;
                state_next = (comp_reg == 2'd3) ? S_COMMIT : S_DIVI;
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // checks
    assign in_beat   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign at_commit = (state_reg == S_COMMIT);
    `QOA_ASSERT_NEXT(a_in_cordic, in_beat, state_reg == S_CORDIC && cnt_reg == '0, "no cordic")
    `QOA_ASSERT_NEXT(a_commit_holds, at_commit && out_stall, at_commit, "result overwritten")
    `QOA_ASSERT_NEXT(a_commit_valid, cmd.op == OP_COMMIT, out_valid && in_ready, "no result")
    `QOA_ASSERT_NOW(a_sqrt_bound, state_reg == S_SQRT, cnt_reg < 5'(SQRT_STEPS), "sqrt overrun")

endmodule
`default_nettype wire
